FILE: rtl/ksp_pkg.sv
`default_nettype none

package ksp_pkg;

  // Widths of the channel payload fields.
  localparam int SORT_KEY_W = 48;
  localparam int POS_W      = 6;

endpackage

`default_nettype wire

FILE: rtl/ksp_in_if.sv
`default_nettype none

interface ksp_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ksp_pkg::SORT_KEY_W-1:0] sort_key;
  logic                                 batch_end;

  modport source (output valid, output sort_key, output batch_end, input ready);
  modport sink   (input valid, input sort_key, input batch_end, output ready);
endinterface

`default_nettype wire

FILE: rtl/ksp_out_if.sv
`default_nettype none

interface ksp_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ksp_pkg::SORT_KEY_W-1:0] sorted_key;
  logic [ksp_pkg::POS_W-1:0]            origin_position;
  logic                                 final_result;

  modport source (output valid, output sorted_key, output origin_position,
                  output final_result, input ready);
  modport sink   (input valid, input sorted_key, input origin_position,
                  input final_result, output ready);
endinterface

`default_nettype wire

FILE: rtl/ksp_mem.sv
`default_nettype none

module ksp_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 54,
  parameter int AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ksp_cmp.sv
`default_nettype none

module ksp_cmp #(
  parameter int SW     = 48,
  parameter bit SIGNED = 1'b1
) (
  input  wire logic [SW-1:0] a,
  input  wire logic [SW-1:0] b,
  output logic               a_gt_b
);

  // Flipping the sign bit turns a signed order into an unsigned one.
  localparam logic [SW-1:0] FLIP = {SIGNED, {(SW-1){1'b0}}};

  assign a_gt_b = (a ^ FLIP) > (b ^ FLIP);

endmodule

`default_nettype wire

FILE: rtl/key_sort_with_positions_core.sv
`default_nettype none

// Loading: ready every cycle while a batch is gathered.
// Sorting: one compare unit, one key/position memory with a read and a write port.
// Emission: after S_EMIT, one result per cycle while results.ready is high.
// The next batch is taken only after the last result has left.
// Reset clears the key count and the sequencer; the memory is not cleared.
module key_sort_with_positions_core #(
  parameter int MAX_ITEMS = 64,
  parameter int KEY_BITS  = 48
) (
  input  wire logic clk,
  input  wire logic rst,
  ksp_in_if.sink    keys,
  ksp_out_if.source results
);

  import ksp_pkg::*;

  localparam int  IW     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int  CW     = $clog2(MAX_ITEMS + 1);
  localparam int  SW     = (KEY_BITS < SORT_KEY_W) ? KEY_BITS : SORT_KEY_W;
  localparam bit  SIGNED = (KEY_BITS <= SORT_KEY_W);
  localparam int  EW     = SW + IW;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_HOLD  = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_PLACE = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;
  localparam logic [2:0] S_SHOW  = 3'd6;

  logic [2:0]    state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] i, i_next;
  logic [CW-1:0] j, j_next;
  logic [CW-1:0] o, o_next;
  logic [SW-1:0] key_hold;
  logic [IW-1:0] pos_hold;
  logic          hold_load;

  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic [EW-1:0] rd_data;
  logic [SW-1:0] rd_key;
  logic [IW-1:0] rd_pos;
  logic          gt;

  logic          in_fire, out_fire, is_final;
  logic [CW-1:0] i_inc, j_dec, j_dec2, count_inc;

  assign rd_key = rd_data[EW-1:IW];
  assign rd_pos = rd_data[IW-1:0];

  ksp_mem #(.DEPTH(MAX_ITEMS), .WIDTH(EW), .AW(IW)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ksp_cmp #(.SW(SW), .SIGNED(SIGNED)) u_cmp (
    .a      (rd_key),
    .b      (key_hold),
    .a_gt_b (gt)
  );

  assign keys.ready    = (state == S_LOAD);
  assign results.valid = (state == S_SHOW);
  assign in_fire       = keys.valid && keys.ready;
  assign out_fire      = results.valid && results.ready;
  assign is_final      = (o == count - 1'b1);

  assign i_inc     = i + 1'b1;
  assign j_dec     = j - 1'b1;
  assign j_dec2    = j - CW'(2);
  assign count_inc = (count < CW'(MAX_ITEMS)) ? count + 1'b1 : count;

  always_comb begin
    results.sorted_key      = '0;
    results.sorted_key[SW-1:0] = rd_key;
    results.origin_position = '0;
    results.origin_position[IW-1:0] = rd_pos;
    results.final_result    = is_final;
  end

  always_comb begin
    state_next = state;
    count_next = count;
    i_next     = i;
    j_next     = j;
    o_next     = o;
    hold_load  = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = j[IW-1:0];
    wr_data    = {key_hold, pos_hold};
    rd_en      = 1'b0;
    rd_addr    = i[IW-1:0];
    unique case (state)
      S_LOAD: begin
        if (in_fire) begin
          // Keys past capacity are dropped, but an end mark still closes the batch.
          if (count < CW'(MAX_ITEMS)) begin
            wr_en   = 1'b1;
            wr_addr = count[IW-1:0];
            wr_data = {keys.sort_key[SW-1:0], count[IW-1:0]};
          end
          count_next = count_inc;
          if (keys.batch_end) begin
            i_next = CW'(1);
            o_next = '0;
            state_next = (count_inc > CW'(1)) ? S_FETCH : S_EMIT;
          end
        end
      end
      S_FETCH: begin
        rd_en      = 1'b1;
        rd_addr    = i[IW-1:0];
        state_next = S_HOLD;
      end
      S_HOLD: begin
        hold_load  = 1'b1;
        j_next     = i;
        rd_en      = 1'b1;
        rd_addr    = i_inc[IW-1:0] - IW'(2);
        state_next = S_CMP;
      end
      S_CMP: begin
        wr_en = 1'b1;
        if (gt) begin
          // Shift the larger neighbor up and look one entry further down.
          wr_addr = j[IW-1:0];
          wr_data = rd_data;
          j_next  = j_dec;
          if (j_dec != '0) begin
            rd_en   = 1'b1;
            rd_addr = j_dec2[IW-1:0];
          end else begin
            wr_en      = 1'b1;
            state_next = S_PLACE;
          end
        end else begin
          wr_addr = j[IW-1:0];
          i_next  = i_inc;
          state_next = (i_inc < count) ? S_FETCH : S_EMIT;
        end
      end
      S_PLACE: begin
        wr_en      = 1'b1;
        wr_addr    = '0;
        i_next     = i_inc;
        state_next = (i_inc < count) ? S_FETCH : S_EMIT;
      end
      S_EMIT: begin
        rd_en      = 1'b1;
        rd_addr    = o[IW-1:0];
        state_next = S_SHOW;
      end
      S_SHOW: begin
        if (out_fire) begin
          if (is_final) begin
            count_next = '0;
            state_next = S_LOAD;
          end else begin
            o_next  = o + 1'b1;
            rd_en   = 1'b1;
            rd_addr = o[IW-1:0] + 1'b1;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      i     <= '0;
      j     <= '0;
      o     <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      i     <= i_next;
      j     <= j_next;
      o     <= o_next;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_load) begin
      key_hold <= rd_key;
      pos_hold <= rd_pos;
    end
  end

  a_out_has_keys: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (count != '0))
    else $error("result shown with an empty batch");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ITEMS))
    else $error("key count beyond capacity");

  a_stream_on: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.ready && !results.final_result) |=> results.valid)
    else $error("result stream stopped before the final beat");

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(keys.ready && results.valid))
    else $error("loading while results are pending");

endmodule

`default_nettype wire

FILE: sim/tb_key_sort_with_positions_core.sv
`timescale 1ns / 1ps

module tb_key_sort_with_positions_core;
  import ksp_pkg::*;

  localparam int CAPACITY    = 64;
  localparam int IDLE_PCT    = 23;
  localparam int SETTLE      = 40;
  localparam int CYCLE_LIMIT = 400000;

  typedef logic signed [SORT_KEY_W-1:0] key_t;

  typedef struct {
    key_t             key;
    logic [POS_W-1:0] pos;
    logic             last;
  } ranked_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   calm = 1'b0;
  int   errors = 0;
  int   cycles = 0;

  ksp_in_if  keys();
  ksp_out_if results();

  // Predictor state: the batch gathered so far and the ranked results it owes.
  key_t             batch_keys[CAPACITY];
  logic [POS_W-1:0] batch_pos[CAPACITY];
  int               batch_len = 0;
  ranked_t          ranked_queue[$];
  key_t             prev_pick = '0;

  key_sort_with_positions_core #(
    .MAX_ITEMS(CAPACITY),
    .KEY_BITS (SORT_KEY_W)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .keys   (keys),
    .results(results)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk) begin
    results.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // Stores one key of the batch and, on the end mark, ranks the batch with a
  // stable insertion sort so equal keys leave in arrival order.
  task automatic absorb_key(input key_t k, input logic last);
    key_t             hold_key;
    logic [POS_W-1:0] hold_pos;
    int               j;
    ranked_t          r;
    if (batch_len < CAPACITY) begin
      batch_keys[batch_len] = k;
      batch_pos[batch_len]  = POS_W'(batch_len);
      batch_len++;
    end
    if (last) begin
      for (int i = 1; i < batch_len; i++) begin
        hold_key = batch_keys[i];
        hold_pos = batch_pos[i];
        j = i;
        while (j > 0 && batch_keys[j-1] > hold_key) begin
          batch_keys[j] = batch_keys[j-1];
          batch_pos[j]  = batch_pos[j-1];
          j--;
        end
        batch_keys[j] = hold_key;
        batch_pos[j]  = hold_pos;
      end
      for (int i = 0; i < batch_len; i++) begin
        r.key  = batch_keys[i];
        r.pos  = batch_pos[i];
        r.last = (i == batch_len - 1);
        ranked_queue.push_back(r);
      end
      batch_len = 0;
    end
  endtask

  task automatic send_key(input key_t k, input logic last);
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      keys.valid <= 1'b0;
      @(negedge clk);
    end
    keys.valid     <= 1'b1;
    keys.sort_key  <= k;
    keys.batch_end <= last;
    do @(posedge clk); while (keys.ready !== 1'b1);
    absorb_key(k, last);
  endtask

  // Drops valid, then waits until every owed result has been taken.
  task automatic wait_drained();
    @(negedge clk);
    keys.valid <= 1'b0;
    while (ranked_queue.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Mix of wide keys, clustered small keys for ties, extremes, repeats and mid-size keys.
  function automatic key_t pick_key();
    logic [63:0] raw;
    int          sel;
    int          n;
    key_t        k;
    raw = {$urandom(), $urandom()};
    sel = $urandom_range(99);
    if (sel < 30) begin
      k = raw[SORT_KEY_W-1:0];
    end else if (sel < 50) begin
      n = $urandom_range(16);
      k = SORT_KEY_W'(n - 8);
    end else if (sel < 65) begin
      case ($urandom_range(4))
        0: k = {1'b0, {(SORT_KEY_W-1){1'b1}}};
        1: k = {1'b1, {(SORT_KEY_W-1){1'b0}}};
        2: k = '0;
        3: k = '1;
        default: k = key_t'(1);
      endcase
    end else if (sel < 85) begin
      k = prev_pick;
    end else begin
      n = int'($urandom()) >>> 12;
      k = SORT_KEY_W'(n);
    end
    prev_pick = k;
    return k;
  endfunction

  task automatic send_batch(input int len);
    for (int i = 0; i < len; i++) send_key(pick_key(), i == len - 1);
  endtask

  task automatic test_extremes();
    key_t top;
    key_t bottom;
    top    = {1'b0, {(SORT_KEY_W-1){1'b1}}};
    bottom = {1'b1, {(SORT_KEY_W-1){1'b0}}};
    send_key(top, 1'b0);
    send_key(bottom, 1'b0);
    send_key('0, 1'b0);
    send_key('1, 1'b0);
    send_key(key_t'(1), 1'b0);
    send_key(bottom + 1, 1'b0);
    send_key(top - 1, 1'b1);
  endtask

  task automatic test_single_keys();
    send_key(pick_key(), 1'b1);
    send_key({1'b1, {(SORT_KEY_W-1){1'b0}}}, 1'b1);
  endtask

  task automatic test_ties();
    send_key(key_t'(5), 1'b0);
    send_key(-key_t'(3), 1'b0);
    send_key(key_t'(5), 1'b0);
    send_key(key_t'(5), 1'b0);
    send_key(-key_t'(3), 1'b0);
    send_key('0, 1'b0);
    send_key(key_t'(5), 1'b1);
  endtask

  task automatic test_presorted();
    for (int i = 0; i < 4; i++) send_key(key_t'(i * 1000 - 1500), i == 3);
    for (int i = 0; i < 5; i++) send_key(key_t'(70000 - i * 65536), i == 4);
  endtask

  // A full batch, a batch whose tail (end mark included) lies past capacity,
  // then a short batch to see positions restart at zero.
  task automatic test_capacity();
    send_batch(CAPACITY);
    send_batch(CAPACITY + 6);
    send_batch(3);
    wait_drained();
  endtask

  task automatic test_steady_stream();
    calm = 1'b1;
    for (int i = 0; i < 8; i++) send_batch($urandom_range(1, 12));
    wait_drained();
    calm = 1'b0;
  endtask

  task automatic test_random_batches(input int item_goal);
    int sent;
    int len;
    int sel;
    sent = 0;
    while (sent < item_goal) begin
      sel = $urandom_range(99);
      if (sel < 70) len = $urandom_range(1, 8);
      else if (sel < 94) len = $urandom_range(9, 30);
      else len = $urandom_range(31, CAPACITY);
      send_batch(len);
      sent += len;
      if ($urandom_range(9) == 0) wait_drained();
    end
  endtask

  always @(posedge clk) begin
    ranked_t want;
    if (!rst && results.valid === 1'b1 && results.ready === 1'b1) begin
      if (ranked_queue.size() == 0) begin
        report_mismatch($sformatf("result with no expectation: key %0d pos %0d",
                                  results.sorted_key, results.origin_position));
      end else begin
        want = ranked_queue.pop_front();
        if (results.sorted_key !== want.key)
          report_mismatch($sformatf("sorted_key got %0d, want %0d",
                                    results.sorted_key, want.key));
        if (results.origin_position !== want.pos)
          report_mismatch($sformatf("origin_position got %0d, want %0d (key %0d)",
                                    results.origin_position, want.pos, want.key));
        if (results.final_result !== want.last)
          report_mismatch($sformatf("final_result got %b, want %b (key %0d)",
                                    results.final_result, want.last, want.key));
      end
    end
  end

  initial begin
    keys.valid     = 1'b0;
    keys.sort_key  = '0;
    keys.batch_end = 1'b0;
    results.ready  = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_extremes();
    test_single_keys();
    test_ties();
    test_presorted();
    test_capacity();
    test_steady_stream();
    test_random_batches(140);

    wait_drained();
    if (ranked_queue.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", ranked_queue.size()));
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/ksp_pkg.sv
rtl/ksp_in_if.sv
rtl/ksp_out_if.sv
rtl/ksp_mem.sv
rtl/ksp_cmp.sv
rtl/key_sort_with_positions_core.sv
sim/tb_key_sort_with_positions_core.sv
